/* design/period_meter_coin_detector_defines.svh */
// Assertion macros for the period meter coin detector checker.
// Depends on nothing; the checker that includes it supplies i_clk and i_rst_n.
`ifndef PERIOD_METER_COIN_DETECTOR_DEFINES_SVH
`define PERIOD_METER_COIN_DETECTOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PMCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pmcd assertion failed");

// Property checked on every clock edge, reset included.
`define PMCD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("pmcd reset assertion failed");

`endif

/* design/pmcd_pkg.sv */
// Shared types, constants and helper functions for the period meter coin detector.
// Depends on nothing; every design module imports it.
package pmcd_pkg;

    // Counter and field widths.
    localparam int CNT_W     = 27;
    localparam int FIELD_W   = 27;
    localparam int PPM_W     = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Measurement queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Register reset values.
    localparam logic [PPM_W-1:0]   RST_PPM        = PPM_W'(100);
    localparam logic [FIELD_W-1:0] RST_SYNC_TMO   = FIELD_W'(393216);
    localparam logic [FIELD_W-1:0] RST_MEAS_TMO   = FIELD_W'(67174400);
    localparam logic [FIELD_W-1:0] RST_SETTLE_TOL = FIELD_W'(150);
    localparam logic [FIELD_W-1:0] RST_DETECT_THR = FIELD_W'(300);

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPM        = 3'd0,
        CFG_SYNC_TMO   = 3'd1,
        CFG_MEAS_TMO   = 3'd2,
        CFG_SETTLE_TOL = 3'd3,
        CFG_DETECT_THR = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PPM_W-1:0]   ppm;
        logic [FIELD_W-1:0] sync_tmo;
        logic [FIELD_W-1:0] meas_tmo;
        logic [FIELD_W-1:0] settle_tol;
        logic [FIELD_W-1:0] detect_thr;
    } t_cfg;

    // One finished measurement handed from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0] value;
        logic             tmo;
    } t_meas;

    // Head of the measurement queue as seen by the back.
    typedef struct packed {
        logic  avail;
        t_meas meas;
    } t_queue_head;

    // A timeout above the counter range acts as the counter maximum.
    function automatic logic [CNT_W-1:0] cap_limit(input logic [FIELD_W-1:0] t);
        logic [32:0] wide_t;
        wide_t = 33'(t);
        if (wide_t > 33'(CNT_MAX)) begin
            cap_limit = CNT_MAX;
        end else begin
            cap_limit = CNT_W'(t);
        end
    endfunction

endpackage

/* design/pmcd_cfg.sv */
// Configuration register file of the period meter coin detector.
// Depends on pmcd_pkg for the register indexes, reset values and t_cfg.
module pmcd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pmcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pmcd_pkg::FIELD_W-1:0]     i_cfg_data,
    output pmcd_pkg::t_cfg                   o_cfg
);
    import pmcd_pkg::*;

    t_cfg r_cfg;

    // Registers load on a write; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppm        <= RST_PPM;
            r_cfg.sync_tmo   <= RST_SYNC_TMO;
            r_cfg.meas_tmo   <= RST_MEAS_TMO;
            r_cfg.settle_tol <= RST_SETTLE_TOL;
            r_cfg.detect_thr <= RST_DETECT_THR;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PPM:        r_cfg.ppm        <= i_cfg_data[PPM_W-1:0];
                CFG_SYNC_TMO:   r_cfg.sync_tmo   <= i_cfg_data;
                CFG_MEAS_TMO:   r_cfg.meas_tmo   <= i_cfg_data;
                CFG_SETTLE_TOL: r_cfg.settle_tol <= i_cfg_data;
                CFG_DETECT_THR: r_cfg.detect_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/pmcd_front.sv */
// Front end: takes one detector sample per item, syncs and times the periods.
// Depends on pmcd_pkg; pushes finished measurements into the queue.
module pmcd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmcd_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_signal_level,
    input  logic           i_q_full,
    output logic           o_push,
    output pmcd_pkg::t_meas o_meas
);
    import pmcd_pkg::*;

    typedef enum logic [1:0] {
        CAP_SYNC_LOW  = 2'd0,
        CAP_SYNC_HIGH = 2'd1,
        CAP_CNT_LOW   = 2'd2,
        CAP_CNT_HIGH  = 2'd3
    } t_cap_phase;

    t_cap_phase       r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PPM_W-1:0] r_edges, n_edges;

    logic             accept;
    logic [CNT_W-1:0] bumped;
    logic [CNT_W-1:0] sync_lim;
    logic [CNT_W-1:0] meas_lim;
    logic [PPM_W-1:0] need;
    logic [PPM_W-1:0] edges_inc;
    logic             emit;
    logic [CNT_W-1:0] emit_val;
    logic             emit_tmo;
    logic             chk_meas;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Saturating tick count and the limits it is checked against.
    assign bumped    = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
    assign sync_lim  = cap_limit(i_cfg.sync_tmo);
    assign meas_lim  = cap_limit(i_cfg.meas_tmo);
    assign need      = (i_cfg.ppm == '0) ? PPM_W'(1) : i_cfg.ppm;
    assign edges_inc = r_edges + PPM_W'(1);

    // Capture sequence for one accepted sample.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_edges  = r_edges;
        emit     = 1'b0;
        emit_val = '0;
        emit_tmo = 1'b0;
        chk_meas = 1'b0;
        if (accept) begin
            case (r_phase)
                CAP_SYNC_LOW: begin
                    if (!i_signal_level) begin
                        n_phase = CAP_SYNC_HIGH;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = bumped;
                        if (bumped >= sync_lim) begin
                            emit     = 1'b1;
                            emit_tmo = 1'b1;
                        end
                    end
                end
                CAP_SYNC_HIGH: begin
                    if (i_signal_level) begin
                        n_phase = CAP_CNT_LOW;
                        n_cnt   = '0;
                        n_edges = '0;
                    end else begin
                        n_cnt = bumped;
                        if (bumped >= sync_lim) begin
                            emit     = 1'b1;
                            emit_tmo = 1'b1;
                        end
                    end
                end
                CAP_CNT_LOW: begin
                    n_cnt    = bumped;
                    chk_meas = 1'b1;
                    if (!i_signal_level) begin
                        n_phase = CAP_CNT_HIGH;
                    end
                end
                CAP_CNT_HIGH: begin
                    n_cnt    = bumped;
                    chk_meas = 1'b1;
                    if (i_signal_level) begin
                        n_edges = edges_inc;
                        if (edges_inc >= need) begin
                            emit     = 1'b1;
                            emit_val = bumped;
                            chk_meas = 1'b0;
                        end else begin
                            n_phase = CAP_CNT_LOW;
                        end
                    end
                end
                default: ;
            endcase
            // The whole count has its own limit.
            if (chk_meas && bumped >= meas_lim) begin
                emit     = 1'b1;
                emit_val = '0;
                emit_tmo = 1'b1;
            end
            if (emit) begin
                n_phase = CAP_SYNC_LOW;
                n_cnt   = '0;
                n_edges = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= CAP_SYNC_LOW;
            r_cnt   <= '0;
            r_edges <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_edges <= n_edges;
        end
    end

    assign o_push       = emit;
    assign o_meas.value = emit_val;
    assign o_meas.tmo   = emit_tmo;

endmodule

/* design/pmcd_fifo.sv */
// Short measurement queue between the front end and the baseline tracker.
// Depends on pmcd_pkg for t_meas, t_queue_head and the queue depth.
module pmcd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pmcd_pkg::t_meas       i_data,
    input  logic                  i_pop,
    output logic                  o_full,
    output pmcd_pkg::t_queue_head o_head
);
    import pmcd_pkg::*;

    t_meas              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    // Entry storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

    assign o_full       = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_head.avail = (r_count != '0);
    assign o_head.meas  = r_mem[r_rd_ptr];

endmodule

/* design/pmcd_back.sv */
// Back end: baseline tracker and registered result item.
// Depends on pmcd_pkg; pops measurements from the queue.
module pmcd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmcd_pkg::t_cfg                i_cfg,
    input  pmcd_pkg::t_queue_head         i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pmcd_pkg::FIELD_W-1:0]  o_period_ticks,
    output logic                          o_timed_out,
    output logic [1:0]                    o_tracker_phase,
    output logic                          o_coin_found
);
    import pmcd_pkg::*;

    typedef enum logic [1:0] {
        TRK_NONE    = 2'd0,
        TRK_SETTLE  = 2'd1,
        TRK_MONITOR = 2'd2
    } t_trk_mode;

    t_trk_mode          r_mode, n_mode;
    logic [CNT_W-1:0]   r_base, n_base;
    logic               n_coin;
    logic               r_valid;
    logic [FIELD_W-1:0] r_ticks;
    logic               r_tmo;
    logic [1:0]         r_phase;
    logic               r_coin;

    logic               take;
    logic [CNT_W-1:0]   value;
    logic [CNT_W-1:0]   diff;
    logic [32:0]        diff_w;

    // The output register accepts a new item when empty or being emptied.
    assign take  = i_head.avail && (!r_valid || i_ready);
    assign o_pop = take;
    assign value = i_head.meas.value;

    // Absolute difference to the current baseline.
    assign diff   = (value > r_base) ? value - r_base : r_base - value;
    assign diff_w = 33'(diff);

    // Tracker update for the measurement at the queue head.
    always_comb begin
        n_mode = r_mode;
        n_base = r_base;
        n_coin = 1'b0;
        case (r_mode)
            TRK_NONE: begin
                n_base = value;
                n_mode = TRK_SETTLE;
            end
            TRK_SETTLE: begin
                if (diff_w > 33'(i_cfg.settle_tol)) begin
                    n_base = value;
                end else begin
                    n_mode = TRK_MONITOR;
                end
            end
            TRK_MONITOR: begin
                if (diff_w > 33'(i_cfg.detect_thr)) begin
                    n_coin = 1'b1;
                    n_mode = TRK_NONE;
                end
            end
            default: ;
        endcase
    end

    // Tracker state and the registered result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= TRK_NONE;
            r_base  <= '0;
            r_valid <= 1'b0;
        end else if (take) begin
            r_mode  <= n_mode;
            r_base  <= n_base;
            r_valid <= 1'b1;
            r_ticks <= FIELD_W'(value);
            r_tmo   <= i_head.meas.tmo;
            r_phase <= n_mode;
            r_coin  <= n_coin;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid         = r_valid;
    assign o_period_ticks  = r_ticks;
    assign o_timed_out     = r_tmo;
    assign o_tracker_phase = r_phase;
    assign o_coin_found    = r_coin;

endmodule

/* design/period_meter_coin_detector.sv */
// Period meter coin detector: a period counter with timeouts and a baseline tracker.
// Depends on pmcd_pkg, pmcd_cfg, pmcd_front, pmcd_fifo and pmcd_back.
//
// Usage:
// The input channel (i_valid, o_ready, i_signal_level) takes one detector
// sample per item, normally one item every clock cycle. The front end syncs
// on a low then high level and times periods_per_measure rising edges; a
// finished or timed-out measurement enters a four-entry queue. The back end
// compares it with the baseline and presents one result item on the output
// channel (o_valid, i_ready and the result fields).
// The item that ends a measurement enters the queue, and the back end pops it into
// the output register. Samples are taken one per cycle while o_ready is high,
// results leave one per cycle while i_ready is high; the queue depth sets how long
// the receiver may stall before o_ready drops. When the receiver stalls, the result
// stays put, the queue fills and then o_ready goes low until room frees up. Reset
// clears the capture sequence, the queue, the tracker and the output, and loads the
// register defaults. The user writes registers through i_cfg_we, i_cfg_idx and
// i_cfg_data only while idle; the block does not enforce it.
module period_meter_coin_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pmcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmcd_pkg::FIELD_W-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_signal_level,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pmcd_pkg::FIELD_W-1:0]    o_period_ticks,
    output logic                            o_timed_out,
    output logic [1:0]                      o_tracker_phase,
    output logic                            o_coin_found
);
    import pmcd_pkg::*;

    t_cfg        cfg;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    t_meas       q_data;
    t_queue_head q_head;

    pmcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pmcd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_signal_level (i_signal_level),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_meas         (q_data)
    );

    pmcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    pmcd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_period_ticks  (o_period_ticks),
        .o_timed_out     (o_timed_out),
        .o_tracker_phase (o_tracker_phase),
        .o_coin_found    (o_coin_found)
    );

endmodule

/* design/pmcd_chk.sv */
// Port-level checker for the period meter coin detector, bound to the top level.
// Depends on pmcd_pkg and the assertion macros in period_meter_coin_detector_defines.svh.
`include "period_meter_coin_detector_defines.svh"

module pmcd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [pmcd_pkg::FIELD_W-1:0]  o_period_ticks,
    input logic                          o_timed_out,
    input logic [1:0]                    o_tracker_phase,
    input logic                          o_coin_found
);
    import pmcd_pkg::*;

    // A shown result item waits until it is taken.
    `PMCD_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid)

    // A timed-out measurement always reports zero ticks.
    `PMCD_ASSERT(a_tmo_zero, o_valid && o_timed_out |-> o_period_ticks == '0)

    // A coin drops the tracker back to having no baseline.
    `PMCD_ASSERT(a_coin_rebase, o_valid && o_coin_found |-> o_tracker_phase == 2'd0)

    // Reset empties the output and the queue.
    `PMCD_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_valid && o_ready)

endmodule

bind period_meter_coin_detector pmcd_chk u_pmcd_chk (.*);

/* tb/period_meter_coin_detector_tb.sv */
// Self-checking testbench for period_meter_coin_detector: a scoreboard class predicts each
// measurement result from the accepted detector samples. Depends on pmcd_pkg and the RTL.
`timescale 1ns / 1ps

module period_meter_coin_detector_tb;
    import pmcd_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        CAP_SYNC_LOW   = 2'd0,
        CAP_SYNC_HIGH  = 2'd1,
        CAP_COUNT_LOW  = 2'd2,
        CAP_COUNT_HIGH = 2'd3
    } t_capture;

    typedef enum logic [1:0] {
        TRK_EMPTY    = 2'd0,
        TRK_SETTLING = 2'd1,
        TRK_MONITOR  = 2'd2
    } t_tracker;

    typedef struct packed {
        logic [FIELD_W-1:0] ticks;
        logic               timed_out;
        logic [1:0]         phase;
        logic               coin;
    } t_coin_result;

    // Predicts measurement results from detector samples and checks the block's results.
    class coin_meter_scoreboard;
        logic [PPM_W-1:0]   periods_per_meas;
        logic [FIELD_W-1:0] sync_limit;
        logic [FIELD_W-1:0] meas_limit;
        logic [FIELD_W-1:0] settle_tol;
        logic [FIELD_W-1:0] detect_thr;
        t_capture           capture;
        logic [CNT_W-1:0]   elapsed;
        logic [PPM_W-1:0]   edges;
        logic [CNT_W-1:0]   baseline;
        t_tracker           tracker;
        t_coin_result       pending_results[$];
        int                 error_count;
        int                 results_seen;

        function new();
            periods_per_meas = RST_PPM;
            sync_limit = RST_SYNC_TMO;
            meas_limit = RST_MEAS_TMO;
            settle_tol = RST_SETTLE_TOL;
            detect_thr = RST_DETECT_THR;
            capture = CAP_SYNC_LOW;
            elapsed = '0;
            edges = '0;
            baseline = '0;
            tracker = TRK_EMPTY;
            error_count = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
            case (idx)
                CFG_PPM:        periods_per_meas = value[PPM_W-1:0];
                CFG_SYNC_TMO:   sync_limit = value;
                CFG_MEAS_TMO:   meas_limit = value;
                CFG_SETTLE_TOL: settle_tol = value;
                CFG_DETECT_THR: detect_thr = value;
                default: ;
            endcase
        endfunction

        // The tick counter saturates instead of wrapping.
        function void count_tick();
            if (elapsed != CNT_MAX) begin
                elapsed = elapsed + 1'b1;
            end
        endfunction

        // A finished or timed-out measurement updates the baseline tracker and
        // queues the result; the next sample starts a new sync.
        function void close_measurement(logic [CNT_W-1:0] value, logic tmo);
            logic [CNT_W-1:0] diff;
            logic             coin;
            t_coin_result     res;
            diff = (value > baseline) ? value - baseline : baseline - value;
            coin = 1'b0;
            case (tracker)
                TRK_EMPTY: begin
                    baseline = value;
                    tracker = TRK_SETTLING;
                end
                TRK_SETTLING: begin
                    if (diff > settle_tol) begin
                        baseline = value;
                    end else begin
                        tracker = TRK_MONITOR;
                    end
                end
                default: begin
                    if (diff > detect_thr) begin
                        coin = 1'b1;
                        tracker = TRK_EMPTY;
                    end
                end
            endcase
            res.ticks = value;
            res.timed_out = tmo;
            res.phase = tracker;
            res.coin = coin;
            pending_results.push_back(res);
            capture = CAP_SYNC_LOW;
            elapsed = '0;
            edges = '0;
        endfunction

        // Advances the capture sequence by one accepted sample. Timeouts share the
        // counter width, so they never need clamping to the counter range.
        function void note_sample(logic level);
            logic [PPM_W-1:0] need;
            need = (periods_per_meas == '0) ? PPM_W'(1) : periods_per_meas;
            case (capture)
                CAP_SYNC_LOW: begin
                    if (!level) begin
                        capture = CAP_SYNC_HIGH;
                        elapsed = '0;
                    end else begin
                        count_tick();
                        if (elapsed >= sync_limit) close_measurement('0, 1'b1);
                    end
                    return;
                end
                CAP_SYNC_HIGH: begin
                    if (level) begin
                        capture = CAP_COUNT_LOW;
                        elapsed = '0;
                        edges = '0;
                    end else begin
                        count_tick();
                        if (elapsed >= sync_limit) close_measurement('0, 1'b1);
                    end
                    return;
                end
                CAP_COUNT_LOW: begin
                    count_tick();
                    if (!level) capture = CAP_COUNT_HIGH;
                end
                default: begin
                    count_tick();
                    if (level) begin
                        edges = edges + 1'b1;
                        if (edges >= need) begin
                            close_measurement(elapsed, 1'b0);
                            return;
                        end
                        capture = CAP_COUNT_LOW;
                    end
                end
            endcase
            if (elapsed >= meas_limit) close_measurement('0, 1'b1);
        endfunction

        task report_mismatch(string what, longint got, longint want_v);
            $display("ERROR result %0d %s: got %0d, expected %0d",
                     results_seen, what, got, want_v);
            error_count++;
        endtask

        task check_result(logic [FIELD_W-1:0] ticks, logic tmo, logic [1:0] phase,
                          logic coin);
            t_coin_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected, ticks", ticks, 0);
                return;
            end
            want = pending_results.pop_front();
            if (ticks !== want.ticks) report_mismatch("period_ticks", ticks, want.ticks);
            if (tmo !== want.timed_out) report_mismatch("timed_out", tmo, want.timed_out);
            if (phase !== want.phase) report_mismatch("tracker_phase", phase, want.phase);
            if (coin !== want.coin) report_mismatch("coin_found", coin, want.coin);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [FIELD_W-1:0]   i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_signal_level;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [FIELD_W-1:0]   o_period_ticks;
    logic                 o_timed_out;
    logic [1:0]           o_tracker_phase;
    logic                 o_coin_found;

    coin_meter_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int cur_sync_limit = 0;
    int stuck_cycles = 0;

    period_meter_coin_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_signal_level  (i_signal_level),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_period_ticks  (o_period_ticks),
        .o_timed_out     (o_timed_out),
        .o_tracker_phase (o_tracker_phase),
        .o_coin_found    (o_coin_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check each accepted result item and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_period_ticks, o_timed_out, o_tracker_phase, o_coin_found);
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: give up when no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STUCK_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one sample item and waits for it to be taken. Valid stays high when
    // the next item follows at once; otherwise it drops for a random gap.
    task automatic push_level(input logic level);
        i_valid <= 1'b1;
        i_signal_level <= level;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(level);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) push_level(level);
    endtask

    task automatic send_wave(input int hi_len, input int lo_len, input int cycles);
        repeat (cycles) begin
            send_run(1'b1, hi_len);
            send_run(1'b0, lo_len);
        end
    endtask

    task automatic release_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds off the sender until every predicted result has come back.
    task automatic wait_drained();
        release_input();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [FIELD_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_register(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with nothing in flight, after the block's latency.
    task automatic apply_settings(input int ppm, input int sync_lim, input int meas_lim,
                                  input int tol, input int thr);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_PPM, FIELD_W'(ppm));
        write_reg(CFG_SYNC_TMO, FIELD_W'(sync_lim));
        write_reg(CFG_MEAS_TMO, FIELD_W'(meas_lim));
        write_reg(CFG_SETTLE_TOL, FIELD_W'(tol));
        write_reg(CFG_DETECT_THR, FIELD_W'(thr));
        cur_sync_limit = sync_lim;
    endtask

    // Random traffic: mostly clean square waves whose period drifts or jumps,
    // plus noise, long constant levels that hit the sync timeout, and pauses.
    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int start_items;
        int hi_len;
        int lo_len;
        int pick;
        start_items = items_sent;
        hi_len = $urandom_range(1, 15);
        lo_len = $urandom_range(1, 15);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent - start_items < 40) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(4) == 0) begin
                    hi_len = $urandom_range(1, 15);
                    lo_len = $urandom_range(1, 15);
                end else begin
                    hi_len = hi_len + $urandom_range(2) - 1;
                    lo_len = lo_len + $urandom_range(2) - 1;
                    hi_len = (hi_len < 1) ? 1 : ((hi_len > 15) ? 15 : hi_len);
                    lo_len = (lo_len < 1) ? 1 : ((lo_len > 15) ? 15 : lo_len);
                end
                send_wave(hi_len, lo_len, $urandom_range(2, 5));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 20)) push_level(1'($urandom_range(1)));
            end else if (pick < 97) begin
                send_run(1'($urandom_range(1)), $urandom_range(1, cur_sync_limit + 4));
            end else begin
                wait_drained();
            end
        end
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_signal_level <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: one full measurement of 100 periods at the default limits.
        send_run(1'b0, 3);
        send_wave(1, 1, 102);

        // Writes to undecoded indexes must leave every register alone.
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_IDX_SPARE_LO, FIELD_W'($urandom));
        write_reg(CFG_IDX_SPARE_HI, '1);

        // Zero timeouts give up on the first tick of any wait.
        apply_settings(1, 0, 0, 0, 0);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        push_level(1'b0);
        push_level(1'b1);

        // Short limits: sync timeouts on both levels, a stuck count, then clean
        // measurements, one finishing exactly on the measure limit.
        apply_settings(1, 3, 6, 0, 0);
        send_run(1'b1, 5);
        push_level(1'b0);
        send_run(1'b0, 4);
        push_level(1'b0);
        send_run(1'b1, 8);
        send_wave(1, 1, 2);
        push_level(1'b1);
        send_run(1'b0, 5);
        push_level(1'b1);

        // Largest limits with a short period count.
        apply_settings(7, 134217727, 134217727, 0, 134217727);
        send_run(1'b0, 2);
        send_wave(1, 1, 2 * 7 + 4);

        // Random phases, each with its own settings and idling pattern.
        apply_settings(2, 12, 60, 2, 6);
        run_random_phase(0, 0);
        apply_settings($urandom_range(1, 4), $urandom_range(5, 20), $urandom_range(20, 80),
                       $urandom_range(0, 5), $urandom_range(0, 12));
        run_random_phase(51, 0);
        apply_settings(0, $urandom_range(3, 10), 40, 1, 3);
        run_random_phase(0, 51);
        apply_settings(3, 16, 134217727, 134217727, 0);
        run_random_phase(30, 30);

        // Let the pipeline empty, then a short tail for stray results.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            sb.report_mismatch("results never delivered", 0, sb.pending_results.size());
        end
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* period_meter_coin_detector.f */
+incdir+design
design/pmcd_pkg.sv
design/pmcd_cfg.sv
design/pmcd_front.sv
design/pmcd_fifo.sv
design/pmcd_back.sv
design/period_meter_coin_detector.sv
design/pmcd_chk.sv
tb/period_meter_coin_detector_tb.sv
